FILE: rtl/tdpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpc_pkg - shared types and constants of the trial division prime counter
// Item layouts, datapath widths and sequencer states.
// ----------------------------------------------------------------------------
package tdpc_pkg;

	localparam int NUM_WIDTH   = 32;
	localparam int COUNT_WIDTH = 32;
	// Divisor never exceeds floor(sqrt(2^NUM_WIDTH - 1)) + 1
	localparam int DIV_WIDTH   = NUM_WIDTH / 2 + 1;
	localparam int BIT_CNT_W   = $clog2(NUM_WIDTH);
	localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(2);

	typedef struct packed {
		logic [NUM_WIDTH-1:0] number;
		logic                 clear_count;
	} req_item_t;

	typedef struct packed {
		logic                   prime_flag;
		logic [COUNT_WIDTH-1:0] prime_total;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_CHECK,
		ST_FINISH
	} seq_state_t;

endpackage

FILE: rtl/trial_division_prime_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_counter_unit - primality test with running prime count
// Tests one number per item by trial division and keeps a saturating tally.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_data) carries one number and
//   a clear_count bit. Hold req_valid with a steady payload until req_stall is
//   low; the unit stalls the request side for the whole test of an item.
//   Response channel (rsp_valid / rsp_stall / rsp_data) returns exactly one
//   item per request: the prime flag and the running prime total, which
//   saturates at its maximum. clear_count zeroes the total before counting.
//   One shared restoring divider runs through all NUM_WIDTH dividend bits for
//   each trial divisor, then a check step either ends the test or moves on to
//   the next divisor. Numbers below two skip the divider and go straight to
//   the finish step; a 32-bit prime near the top of the range is the slowest.
//   One item is in work at a time; the next is taken once the result sits in
//   the response register, even while the receiver stalls it.
//   Reset (arst_n low) clears the total and returns the sequencer to idle.
//   A stalled response holds its value; the unit waits at the end of the next
//   test until the response register is free.
// ----------------------------------------------------------------------------
module trial_division_prime_counter_unit
	import tdpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req_data,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp_data
);

	seq_state_t state_q, state_d;

	// Datapath registers
	logic [NUM_WIDTH-1:0]   held_number_q;   // number under test
	logic [NUM_WIDTH-1:0]   dividend_q;      // shifts out one bit a cycle while dividing
	logic [NUM_WIDTH-1:0]   quotient_q;
	logic [DIV_WIDTH-1:0]   remainder_q;
	logic [DIV_WIDTH-1:0]   divisor_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic                   prime_q;
	logic [COUNT_WIDTH-1:0] tally_q;
	logic                   rsp_valid_q;
	rsp_item_t              rsp_data_q;

	// Control strobes from the sequencer
	logic take_req, start_div, step_div, next_div, set_prime, clr_prime, emit_rsp;

	// Shared divider step: bring down the next dividend bit, try to subtract
	logic [DIV_WIDTH:0] trial_rem;
	logic [DIV_WIDTH:0] trial_diff;
	logic               trial_fits;
	logic               last_bit;
	logic               divisor_gt_quot;
	logic               number_small;

	assign trial_rem       = {remainder_q, dividend_q[NUM_WIDTH-1]};
	assign trial_diff      = trial_rem - {1'b0, divisor_q};
	assign trial_fits      = (trial_rem >= {1'b0, divisor_q});
	assign last_bit        = (bit_cnt_q == BIT_CNT_W'(NUM_WIDTH - 1));
	// Loop ends once d exceeds n / d, i.e. d * d > n
	assign divisor_gt_quot = (NUM_WIDTH'(divisor_q) > quotient_q);
	assign number_small    = (req_data.number < NUM_WIDTH'(2));

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		take_req  = 1'b0;
		start_div = 1'b0;
		step_div  = 1'b0;
		next_div  = 1'b0;
		set_prime = 1'b0;
		clr_prime = 1'b0;
		emit_rsp  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					take_req = 1'b1;
					// Zero and one are not prime: skip the divider
					if (number_small) begin
						clr_prime = 1'b1;
						state_d   = ST_FINISH;
					end else begin
						start_div = 1'b1;
						state_d   = ST_DIVIDE;
					end
				end
			end
			ST_DIVIDE: begin
				step_div = 1'b1;
				if (last_bit) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (divisor_gt_quot) begin
					set_prime = 1'b1;
					state_d   = ST_FINISH;
				end else if (remainder_q == '0) begin
					clr_prime = 1'b1;
					state_d   = ST_FINISH;
				end else begin
					next_div = 1'b1;
					state_d  = ST_DIVIDE;
				end
			end
			ST_FINISH: begin
				// Wait for the response register to drain
				if (!rsp_valid_q || !rsp_stall) begin
					emit_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Divider datapath; payload only, no reset
	always_ff @(posedge clk) begin
		if (take_req) begin
			held_number_q <= req_data.number;
			dividend_q    <= req_data.number;
		end
		if (start_div) begin
			divisor_q   <= FIRST_DIVISOR;
			remainder_q <= '0;
			quotient_q  <= '0;
			bit_cnt_q   <= '0;
		end else if (next_div) begin
			// Advance to the next trial divisor and restart the division
			divisor_q   <= divisor_q + DIV_WIDTH'(1);
			dividend_q  <= held_number_q;
			remainder_q <= '0;
			quotient_q  <= '0;
			bit_cnt_q   <= '0;
		end else if (step_div) begin
			dividend_q  <= {dividend_q[NUM_WIDTH-2:0], 1'b0};
			quotient_q  <= {quotient_q[NUM_WIDTH-2:0], trial_fits};
			remainder_q <= trial_fits ? trial_diff[DIV_WIDTH-1:0]
			                          : trial_rem[DIV_WIDTH-1:0];
			bit_cnt_q   <= bit_cnt_q + BIT_CNT_W'(1);
		end
		if (set_prime) begin
			prime_q <= 1'b1;
		end else if (clr_prime) begin
			prime_q <= 1'b0;
		end
		if (emit_rsp) begin
			rsp_data_q.prime_flag  <= prime_q;
			rsp_data_q.prime_total <= (prime_q && (tally_q != '1))
			                          ? tally_q + COUNT_WIDTH'(1) : tally_q;
		end
	end

	// Running tally and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take_req && req_data.clear_count) begin
				tally_q <= '0;
			end else if (emit_rsp && prime_q && (tally_q != '1)) begin
				tally_q <= tally_q + COUNT_WIDTH'(1);
			end
			if (emit_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule
